FILE: design/plasm_pkg.sv
// ----------------------------------------------------------------------------
// plasm_pkg
// Shared types, widths and helpers for the posting list builder.
// ----------------------------------------------------------------------------
package plasm_pkg;

  localparam int CAPACITY = 1024;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int PTR_W    = CNT_W + 1;
  localparam int DOC_W    = 64;
  localparam int FREQ_W   = 32;
  localparam int IDX_W    = 10;
  localparam int ENT_W    = DOC_W + FREQ_W;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_SORT  = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef struct packed {
    op_t               op;
    logic [DOC_W-1:0]  doc;
    logic [FREQ_W-1:0] freq;
    logic [IDX_W-1:0]  idx;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

  // Saturating add: bit FREQ_W flags saturation.
  function automatic logic [FREQ_W:0] sat_add(logic [FREQ_W-1:0] a,
                                              logic [FREQ_W-1:0] b);
    logic [FREQ_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s[FREQ_W]) begin
      s = {1'b1, {FREQ_W{1'b1}}};
    end
    return s;
  endfunction

endpackage

FILE: design/posting_list_accumulate_sort_merge.sv
// ----------------------------------------------------------------------------
// posting_list_accumulate_sort_merge
// Posting list of (document id, frequency) entries with accumulate, sort and
// merge, indexed read and clear.
//
//   channel | ports                                          | dir
//   in      | in_valid in_stall in_mode in_doc_id in_freq   | in
//           | in_index                                       |
//   out     | out_valid out_stall out_status out_entry_count | out
//           | out_entry_doc out_entry_freq out_last_matches  |
//           | out_sum_saturated                              |
//
// Read adds a wait state for the registered RAM read; add and clear do not.
// Sort runs ceil(log2 n) bottom-up merge passes and then a merging pass of
// equal ids, all through the single bank read port.
// A two-beat input queue keeps accepting while the back end works, until full.
// Reset empties the list by zeroing the entry count; no clearing pass is needed.
// ----------------------------------------------------------------------------
module posting_list_accumulate_sort_merge import plasm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_mode,
  input  logic [DOC_W-1:0]  in_doc_id,
  input  logic [FREQ_W-1:0] in_freq,
  input  logic [IDX_W-1:0]  in_index,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_status,
  output logic [CNT_W-1:0]  out_entry_count,
  output logic [DOC_W-1:0]  out_entry_doc,
  output logic [FREQ_W-1:0] out_entry_freq,
  output logic              out_last_matches,
  output logic              out_sum_saturated
);

  head_t head;
  logic  pop;

  plasm_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_mode(in_mode),
    .in_doc_id(in_doc_id), .in_freq(in_freq), .in_index(in_index),
    .head(head), .pop(pop));

  plasm_back u_back (
    .clk(clk), .rst_n(rst_n), .head(head), .pop(pop),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_entry_count(out_entry_count), .out_entry_doc(out_entry_doc),
    .out_entry_freq(out_entry_freq), .out_last_matches(out_last_matches),
    .out_sum_saturated(out_sum_saturated));

endmodule

FILE: design/plasm_ram.sv
// ----------------------------------------------------------------------------
// plasm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module plasm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/plasm_front.sv
// ----------------------------------------------------------------------------
// plasm_front
// Accepts input beats, decodes the mode and holds them in a two-slot queue.
// ----------------------------------------------------------------------------
module plasm_front import plasm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_mode,
  input  logic [DOC_W-1:0]  in_doc_id,
  input  logic [FREQ_W-1:0] in_freq,
  input  logic [IDX_W-1:0]  in_index,
  output head_t             head,
  input  logic              pop
);

  item_t      slot_r [2];
  logic       wr_r, rd_r;
  logic [1:0] fill_r;
  item_t      item_in;
  logic       push;

  always_comb begin
    item_in.op   = op_t'(in_mode);
    item_in.doc  = in_doc_id;
    item_in.freq = in_freq;
    item_in.idx  = in_index;
  end

  assign in_stall   = (fill_r == 2'd2);
  assign push       = in_valid && !in_stall;
  assign head.valid = (fill_r != 2'd0);
  assign head.item  = slot_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_r] <= item_in;
    end
    if (!rst_n) begin
      wr_r   <= 1'b0;
      rd_r   <= 1'b0;
      fill_r <= 2'd0;
    end else begin
      if (push) wr_r <= !wr_r;
      if (pop)  rd_r <= !rd_r;
      fill_r <= fill_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

FILE: design/plasm_back.sv
// ----------------------------------------------------------------------------
// plasm_back
// Executes queued operations on two ping-pong entry banks: append and
// accumulate, indexed read, clear, and a bottom-up merge sort followed by a
// merging pass of equal ids.
// ----------------------------------------------------------------------------
module plasm_back import plasm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  head_t             head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_status,
  output logic [CNT_W-1:0]  out_entry_count,
  output logic [DOC_W-1:0]  out_entry_doc,
  output logic [FREQ_W-1:0] out_entry_freq,
  output logic              out_last_matches,
  output logic              out_sum_saturated
);

  typedef enum logic [3:0] {
    S_IDLE, S_RDW, S_BLK, S_IA, S_RA, S_RB, S_MRG, S_D0, S_DI, S_DW, S_FIN
  } state_t;

  state_t            state_r, state_nxt;
  logic              cur_r, cur_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DOC_W-1:0]  last_doc_r, last_doc_nxt;
  logic [FREQ_W-1:0] last_freq_r, last_freq_nxt;
  item_t             item_r, item_nxt;
  status_t           status_r, status_nxt;
  logic [DOC_W-1:0]  rd_doc_r, rd_doc_nxt;
  logic [FREQ_W-1:0] rd_freq_r, rd_freq_nxt;
  logic              sat_r, sat_nxt;
  logic [PTR_W-1:0]  w_r, w_nxt, lo_r, lo_nxt, mid_r, mid_nxt, hi_r, hi_nxt;
  logic [PTR_W-1:0]  i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [DOC_W-1:0]  a_doc_r, a_doc_nxt, b_doc_r, b_doc_nxt;
  logic [FREQ_W-1:0] a_freq_r, a_freq_nxt, b_freq_r, b_freq_nxt;
  logic              ov_r, ov_nxt;
  logic [1:0]        o_status_r, o_status_nxt;
  logic [CNT_W-1:0]  o_cnt_r, o_cnt_nxt;
  logic [DOC_W-1:0]  o_doc_r, o_doc_nxt;
  logic [FREQ_W-1:0] o_freq_r, o_freq_nxt;
  logic              o_match_r, o_match_nxt, o_sat_r, o_sat_nxt;

  logic              we, wbank;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [ENT_W-1:0]  wdata, rd0, rd1, rdata;
  logic [DOC_W-1:0]  r_doc;
  logic [FREQ_W-1:0] r_freq;
  logic [FREQ_W:0]   sum;
  logic [PTR_W-1:0]  n, t, nx;
  logic              take_a;

  plasm_ram #(.WIDTH(ENT_W), .DEPTH(CAPACITY)) u_bank0 (
    .clk(clk), .we(we && !wbank), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rd0));
  plasm_ram #(.WIDTH(ENT_W), .DEPTH(CAPACITY)) u_bank1 (
    .clk(clk), .we(we && wbank), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rd1));

  assign rdata  = cur_r ? rd1 : rd0;
  assign r_doc  = rdata[ENT_W-1:FREQ_W];
  assign r_freq = rdata[FREQ_W-1:0];
  assign n      = PTR_W'(cnt_r);

  always_comb begin
    state_nxt = state_r;  cur_nxt = cur_r;  cnt_nxt = cnt_r;
    last_doc_nxt = last_doc_r;  last_freq_nxt = last_freq_r;
    item_nxt = item_r;  status_nxt = status_r;
    rd_doc_nxt = rd_doc_r;  rd_freq_nxt = rd_freq_r;  sat_nxt = sat_r;
    w_nxt = w_r;  lo_nxt = lo_r;  mid_nxt = mid_r;  hi_nxt = hi_r;
    i_nxt = i_r;  j_nxt = j_r;  k_nxt = k_r;
    a_doc_nxt = a_doc_r;  a_freq_nxt = a_freq_r;
    b_doc_nxt = b_doc_r;  b_freq_nxt = b_freq_r;
    ov_nxt = ov_r && out_stall;
    o_status_nxt = o_status_r;  o_cnt_nxt = o_cnt_r;  o_doc_nxt = o_doc_r;
    o_freq_nxt = o_freq_r;  o_match_nxt = o_match_r;  o_sat_nxt = o_sat_r;
    pop = 1'b0;  we = 1'b0;  wbank = !cur_r;
    waddr = '0;  wdata = '0;  raddr = '0;
    sum = '0;  t = '0;  nx = '0;  take_a = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (head.valid) begin
          pop         = 1'b1;
          item_nxt    = head.item;
          status_nxt  = ST_OK;
          rd_doc_nxt  = '0;
          rd_freq_nxt = '0;
          sat_nxt     = 1'b0;
          state_nxt   = S_FIN;
          unique case (head.item.op)
            OP_ADD: begin
              wbank = cur_r;
              if (cnt_r != '0 && last_doc_r == head.item.doc) begin
                sum           = sat_add(last_freq_r, head.item.freq);
                sat_nxt       = sum[FREQ_W];
                last_freq_nxt = sum[FREQ_W-1:0];
                we            = 1'b1;
                waddr         = ADDR_W'(cnt_r - 1'b1);
                wdata         = {last_doc_r, sum[FREQ_W-1:0]};
              end else if (cnt_r < CNT_W'(CAPACITY)) begin
                we            = 1'b1;
                waddr         = ADDR_W'(cnt_r);
                wdata         = {head.item.doc, head.item.freq};
                cnt_nxt       = cnt_r + 1'b1;
                last_doc_nxt  = head.item.doc;
                last_freq_nxt = head.item.freq;
              end else begin
                status_nxt = ST_FULL;
              end
            end
            OP_SORT: begin
              if (cnt_r > CNT_W'(1)) begin
                w_nxt     = PTR_W'(1);
                lo_nxt    = '0;
                state_nxt = S_BLK;
              end
            end
            OP_READ: begin
              if (CNT_W'(head.item.idx) < cnt_r) begin
                raddr     = ADDR_W'(head.item.idx);
                state_nxt = S_RDW;
              end else begin
                status_nxt = ST_RANGE;
              end
            end
            default: begin
              cnt_nxt = '0;
            end
          endcase
        end
      end
      S_RDW: begin
        rd_doc_nxt  = r_doc;
        rd_freq_nxt = r_freq;
        state_nxt   = S_FIN;
      end
      S_BLK: begin
        t         = lo_r + w_r;
        mid_nxt   = (t > n) ? n : t;
        t         = lo_r + (w_r << 1);
        hi_nxt    = (t > n) ? n : t;
        i_nxt     = lo_r;
        j_nxt     = (lo_r + w_r > n) ? n : lo_r + w_r;
        k_nxt     = lo_r;
        raddr     = ADDR_W'(lo_r);
        state_nxt = S_IA;
      end
      S_IA: begin
        a_doc_nxt  = r_doc;
        a_freq_nxt = r_freq;
        if (j_r < hi_r) begin
          raddr     = ADDR_W'(j_r);
          state_nxt = S_RB;
        end else begin
          state_nxt = S_MRG;
        end
      end
      S_RA: begin
        a_doc_nxt  = r_doc;
        a_freq_nxt = r_freq;
        state_nxt  = S_MRG;
      end
      S_RB: begin
        b_doc_nxt  = r_doc;
        b_freq_nxt = r_freq;
        state_nxt  = S_MRG;
      end
      S_MRG: begin
        if (i_r < mid_r || j_r < hi_r) begin
          take_a = (j_r >= hi_r) || (i_r < mid_r && a_doc_r <= b_doc_r);
          we     = 1'b1;
          waddr  = ADDR_W'(k_r);
          wdata  = take_a ? {a_doc_r, a_freq_r} : {b_doc_r, b_freq_r};
          k_nxt  = k_r + 1'b1;
          if (take_a) begin
            nx    = i_r + 1'b1;
            i_nxt = nx;
            if (nx < mid_r) begin
              raddr     = ADDR_W'(nx);
              state_nxt = S_RA;
            end
          end else begin
            nx    = j_r + 1'b1;
            j_nxt = nx;
            if (nx < hi_r) begin
              raddr     = ADDR_W'(nx);
              state_nxt = S_RB;
            end
          end
        end else begin
          t = lo_r + (w_r << 1);
          if (t < n) begin
            lo_nxt    = t;
            state_nxt = S_BLK;
          end else begin
            cur_nxt = !cur_r;
            nx      = w_r << 1;
            w_nxt   = nx;
            lo_nxt  = '0;
            if (nx < n) begin
              state_nxt = S_BLK;
            end else begin
              raddr     = '0;
              state_nxt = S_D0;
            end
          end
        end
      end
      S_D0: begin
        a_doc_nxt  = r_doc;
        a_freq_nxt = r_freq;
        i_nxt      = PTR_W'(1);
        k_nxt      = '0;
        state_nxt  = S_DI;
      end
      S_DI: begin
        if (i_r < n) begin
          raddr     = ADDR_W'(i_r);
          state_nxt = S_DW;
        end else begin
          we            = 1'b1;
          waddr         = ADDR_W'(k_r);
          wdata         = {a_doc_r, a_freq_r};
          cnt_nxt       = CNT_W'(k_r + 1'b1);
          last_doc_nxt  = a_doc_r;
          last_freq_nxt = a_freq_r;
          cur_nxt       = !cur_r;
          state_nxt     = S_FIN;
        end
      end
      S_DW: begin
        if (r_doc == a_doc_r) begin
          sum        = sat_add(a_freq_r, r_freq);
          a_freq_nxt = sum[FREQ_W-1:0];
          sat_nxt    = sat_r || sum[FREQ_W];
        end else begin
          we         = 1'b1;
          waddr      = ADDR_W'(k_r);
          wdata      = {a_doc_r, a_freq_r};
          k_nxt      = k_r + 1'b1;
          a_doc_nxt  = r_doc;
          a_freq_nxt = r_freq;
        end
        i_nxt     = i_r + 1'b1;
        state_nxt = S_DI;
      end
      default: begin
        if (!ov_r || !out_stall) begin
          ov_nxt       = 1'b1;
          o_status_nxt = status_r;
          o_cnt_nxt    = cnt_r;
          o_doc_nxt    = rd_doc_r;
          o_freq_nxt   = rd_freq_r;
          o_match_nxt  = (cnt_r != '0) && (last_doc_r == item_r.doc);
          o_sat_nxt    = sat_r;
          state_nxt    = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cur_r   <= 1'b0;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cur_r   <= cur_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
    end
    last_doc_r  <= last_doc_nxt;   last_freq_r <= last_freq_nxt;
    item_r      <= item_nxt;       status_r    <= status_nxt;
    rd_doc_r    <= rd_doc_nxt;     rd_freq_r   <= rd_freq_nxt;
    sat_r       <= sat_nxt;
    w_r <= w_nxt;  lo_r <= lo_nxt;  mid_r <= mid_nxt;  hi_r <= hi_nxt;
    i_r <= i_nxt;  j_r <= j_nxt;    k_r <= k_nxt;
    a_doc_r <= a_doc_nxt;  a_freq_r <= a_freq_nxt;
    b_doc_r <= b_doc_nxt;  b_freq_r <= b_freq_nxt;
    o_status_r <= o_status_nxt;  o_cnt_r <= o_cnt_nxt;
    o_doc_r    <= o_doc_nxt;     o_freq_r <= o_freq_nxt;
    o_match_r  <= o_match_nxt;   o_sat_r  <= o_sat_nxt;
  end

  assign out_valid         = ov_r;
  assign out_status        = o_status_r;
  assign out_entry_count   = o_cnt_r;
  assign out_entry_doc     = o_doc_r;
  assign out_entry_freq    = o_freq_r;
  assign out_last_matches  = o_match_r;
  assign out_sum_saturated = o_sat_r;

endmodule
